[hdl/volume_index_tracker_assert.svh]
// assertion macros shared by the volume index tracker checkers
`ifndef VOLUME_INDEX_TRACKER_ASSERT_SVH
`define VOLUME_INDEX_TRACKER_ASSERT_SVH

// consequence checked in the same cycle as the antecedent
`define VIT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define VIT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/vit_pkg.sv]
// types, constants and widths shared by the volume index tracker
`timescale 1ns / 1ps
`default_nettype none

package vit_pkg;

  // field widths
  localparam int PRICE_WIDTH  = 32;
  localparam int VOLUME_WIDTH = 48;
  localparam int INDEX_WIDTH  = 48;
  localparam int FRAC_BITS    = 16;

  // index constants, q32.16
  localparam logic [INDEX_WIDTH-1:0] INDEX_START = INDEX_WIDTH'(1000) << FRAC_BITS;
  localparam logic [INDEX_WIDTH-1:0] INDEX_MAX   = '1;

  // radix-4 serial multiplier, multiplier padded to an even width
  localparam int MUL_STEPS  = (PRICE_WIDTH + 1) / 2;
  localparam int MUL_BITS   = 2 * MUL_STEPS;
  localparam int PROD_WIDTH = INDEX_WIDTH + MUL_BITS;

  // shared step counter for multiply and divide
  localparam int STEP_MAX  = (INDEX_WIDTH > MUL_STEPS) ? INDEX_WIDTH : MUL_STEPS;
  localparam int CNT_WIDTH = $clog2(STEP_MAX);

  // command queue between front and back
  localparam int FIFO_DEPTH       = 2;
  localparam int FIFO_PTR_WIDTH   = $clog2(FIFO_DEPTH);
  localparam int FIFO_COUNT_WIDTH = $clog2(FIFO_DEPTH + 1);

  // configuration port
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 3;
  typedef logic [APB_ADDR_WIDTH-3:0] reg_index_t;
  localparam reg_index_t REG_POSITIVE_MODE = '0;

  // command classes decided by the front
  typedef enum logic [1:0] {
    CMD_START,
    CMD_HOLD,
    CMD_SCALE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                op;
    logic [PRICE_WIDTH-1:0] close;
    logic [PRICE_WIDTH-1:0] divisor;
  } cmd_t;

  // head of the command queue as seen by the back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_MUL,
    BK_CHECK,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

[hdl/vit_front.sv]
// front end: takes bars, tracks previous close and volume, classifies each bar
`timescale 1ns / 1ps
`default_nettype none

module vit_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             positive_mode,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [vit_pkg::PRICE_WIDTH-1:0]  close_price,
  input  wire logic [vit_pkg::VOLUME_WIDTH-1:0] bar_volume,
  input  wire logic                             fifo_full,
  output logic                                  cmd_push,
  output vit_pkg::cmd_t                         cmd
);

  logic                             started;
  logic [vit_pkg::PRICE_WIDTH-1:0]  last_close;
  logic [vit_pkg::VOLUME_WIDTH-1:0] last_volume;
  logic                             vol_match;

  assign full     = fifo_full;
  assign cmd_push = push && !fifo_full;

  // volume condition for the selected index flavor
  assign vol_match = positive_mode ? (bar_volume > last_volume)
                                   : (bar_volume < last_volume);

  // classify the bar
  always_comb begin
    cmd.close   = close_price;
    cmd.divisor = last_close;
    if (!started) begin
      cmd.op = vit_pkg::CMD_START;
    end else if (vol_match && (last_close != '0)) begin
      cmd.op = vit_pkg::CMD_SCALE;
    end else begin
      cmd.op = vit_pkg::CMD_HOLD;
    end
  end

  // previous bar state
  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      last_close  <= '0;
      last_volume <= '0;
    end else if (cmd_push) begin
      started     <= 1'b1;
      last_close  <= close_price;
      last_volume <= bar_volume;
    end
  end

endmodule

`default_nettype wire

[hdl/vit_cmd_fifo.sv]
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module vit_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire vit_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output vit_pkg::cmd_slot_t head
);

  vit_pkg::cmd_t                          entries [vit_pkg::FIFO_DEPTH];
  logic [vit_pkg::FIFO_PTR_WIDTH-1:0]     wr_ptr;
  logic [vit_pkg::FIFO_PTR_WIDTH-1:0]     rd_ptr;
  logic [vit_pkg::FIFO_COUNT_WIDTH-1:0]   count;
  logic                                   do_push;
  logic                                   do_pop;

  assign full       = (count == vit_pkg::FIFO_COUNT_WIDTH'(vit_pkg::FIFO_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/vit_back.sv]
// back end: serial multiply and restoring divide of the running index
`timescale 1ns / 1ps
`default_nettype none

module vit_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire vit_pkg::cmd_slot_t              head,
  output logic                                 cmd_pop,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [vit_pkg::INDEX_WIDTH-1:0]      index_value,
  output logic                                 index_updated
);

  localparam int IW = vit_pkg::INDEX_WIDTH;
  localparam int MB = vit_pkg::MUL_BITS;
  localparam int PW = vit_pkg::PROD_WIDTH;

  vit_pkg::back_state_t                  state;
  vit_pkg::back_state_t                  state_next;
  logic [vit_pkg::CNT_WIDTH-1:0]         cnt;
  logic [IW-1:0]                         running_index;
  logic [IW+1:0]                         idx3;
  logic [PW-1:0]                         prod;
  logic [MB-1:0]                         rem;
  logic [IW-1:0]                         quo;
  logic [vit_pkg::PRICE_WIDTH-1:0]       close;
  logic [vit_pkg::PRICE_WIDTH-1:0]       divisor;
  logic                                  res_updated;
  logic                                  out_valid;
  logic                                  out_load;

  logic [IW+1:0]                         addend;
  logic [IW+1:0]                         mul_sum;
  logic [PW-1:0]                         mul_next;
  logic                                  sat;
  logic [MB:0]                           div_trial;
  logic [MB:0]                           div_diff;
  logic                                  div_ge;
  logic [MB-1:0]                         rem_next;
  logic [IW-1:0]                         quo_next;

  assign empty = !out_valid;

  // radix-4 multiply step: add digit times index into the upper half, shift by two
  always_comb begin
    case (prod[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, running_index};
      2'd2:    addend = {1'b0, running_index, 1'b0};
      2'd3:    addend = idx3;
      default: addend = '0;
    endcase
  end
  assign mul_sum  = {2'b00, prod[PW-1:MB]} + addend;
  assign mul_next = {mul_sum, prod[MB-1:2]};

  // quotient overflows the index exactly when the top part reaches the divisor
  assign sat = (prod[PW-1:IW] >= MB'(divisor));

  // restoring divide step
  assign div_trial = {rem, quo[IW-1]};
  assign div_ge    = (div_trial >= (MB+1)'(divisor));
  assign div_diff  = div_trial - (MB+1)'(divisor);
  assign rem_next  = div_ge ? div_diff[MB-1:0] : div_trial[MB-1:0];
  assign quo_next  = {quo[IW-2:0], div_ge};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vit_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    out_load   = 1'b0;
    case (state)
      vit_pkg::BK_IDLE: begin
        if (head.valid) begin
          cmd_pop = 1'b1;
          if (head.cmd.op == vit_pkg::CMD_SCALE) begin
            state_next = vit_pkg::BK_PREP;
          end else begin
            state_next = vit_pkg::BK_DONE;
          end
        end
      end
      vit_pkg::BK_PREP: begin
        state_next = vit_pkg::BK_MUL;
      end
      vit_pkg::BK_MUL: begin
        if (cnt == '0) begin
          state_next = vit_pkg::BK_CHECK;
        end
      end
      vit_pkg::BK_CHECK: begin
        state_next = sat ? vit_pkg::BK_DONE : vit_pkg::BK_DIV;
      end
      vit_pkg::BK_DIV: begin
        if (cnt == '0) begin
          state_next = vit_pkg::BK_DONE;
        end
      end
      vit_pkg::BK_DONE: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = vit_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = vit_pkg::BK_IDLE;
      end
    endcase
  end

  // running index, only changes at command start or end of an operation
  always_ff @(posedge clk) begin
    if (rst) begin
      running_index <= '0;
    end else begin
      if ((state == vit_pkg::BK_IDLE) && head.valid &&
          (head.cmd.op == vit_pkg::CMD_START)) begin
        running_index <= vit_pkg::INDEX_START;
      end
      if ((state == vit_pkg::BK_CHECK) && sat) begin
        running_index <= vit_pkg::INDEX_MAX;
      end
      if ((state == vit_pkg::BK_DIV) && (cnt == '0)) begin
        running_index <= quo_next;
      end
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk) begin
    case (state)
      vit_pkg::BK_IDLE: begin
        close       <= head.cmd.close;
        divisor     <= head.cmd.divisor;
        res_updated <= (head.cmd.op == vit_pkg::CMD_SCALE);
      end
      vit_pkg::BK_PREP: begin
        idx3 <= {2'b00, running_index} + {1'b0, running_index, 1'b0};
        prod <= {{IW{1'b0}}, MB'(close)};
        cnt  <= vit_pkg::CNT_WIDTH'(vit_pkg::MUL_STEPS - 1);
      end
      vit_pkg::BK_MUL: begin
        prod <= mul_next;
        cnt  <= cnt - 1'b1;
      end
      vit_pkg::BK_CHECK: begin
        rem <= prod[PW-1:IW];
        quo <= prod[IW-1:0];
        cnt <= vit_pkg::CNT_WIDTH'(IW - 1);
      end
      vit_pkg::BK_DIV: begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      index_value   <= running_index;
      index_updated <= res_updated;
    end
  end

endmodule

`default_nettype wire

[hdl/volume_index_tracker.sv]
// top level of the negative / positive volume index tracker
//
//  channel   direction  handshake           payload
//  bars      in         push / full         close_price, bar_volume
//  results   out        pop / empty         index_value, index_updated
//  config    in         psel/penable/pwrite paddr, pwdata, prdata (positive_mode)
//
// a scaling bar passes through take, setup, 16 radix-4 multiply
// steps, an overflow check, 48 restoring divide steps and the result load.
// a saturating bar skips the divide; an unscaled bar goes from take to load.
// a two-entry command queue lets the front take bars while the back computes.
// the result register holds a finished transaction until pop; the back stalls.
// rst is synchronous and clears the previous bar state, queue and result.
`timescale 1ns / 1ps
`default_nettype none

module volume_index_tracker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [vit_pkg::PRICE_WIDTH-1:0]    close_price,
  input  wire logic [vit_pkg::VOLUME_WIDTH-1:0]   bar_volume,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [vit_pkg::INDEX_WIDTH-1:0]         index_value,
  output logic                                    index_updated,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [vit_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  wire logic [vit_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [vit_pkg::APB_DATA_WIDTH-1:0]      prdata,
  output logic                                    pready
);

  logic                 positive_mode;
  vit_pkg::reg_index_t  reg_index;
  logic                 cfg_write;
  logic                 fifo_full;
  logic                 cmd_push;
  vit_pkg::cmd_t        cmd;
  vit_pkg::cmd_slot_t   head;
  logic                 cmd_pop;

  // configuration register
  assign pready    = 1'b1;
  assign reg_index = paddr[vit_pkg::APB_ADDR_WIDTH-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      positive_mode <= 1'b0;
    end else if (cfg_write && (reg_index == vit_pkg::REG_POSITIVE_MODE)) begin
      positive_mode <= pwdata[0];
    end
  end

  assign prdata = (reg_index == vit_pkg::REG_POSITIVE_MODE) ?
                  vit_pkg::APB_DATA_WIDTH'(positive_mode) : '0;

  // bar classification
  vit_front u_front (
    .clk          (clk),
    .rst          (rst),
    .positive_mode(positive_mode),
    .push         (push),
    .full         (full),
    .close_price  (close_price),
    .bar_volume   (bar_volume),
    .fifo_full    (fifo_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd)
  );

  // command queue
  vit_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .push_cmd(cmd),
    .full    (fifo_full),
    .pop     (cmd_pop),
    .head    (head)
  );

  // index arithmetic and result register
  vit_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .cmd_pop      (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .index_value  (index_value),
    .index_updated(index_updated)
  );

endmodule

`default_nettype wire

[hdl/vit_checker.sv]
// port-level checker for the volume index tracker, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "volume_index_tracker_assert.svh"

module vit_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           empty,
  input wire logic                           pop,
  input wire logic [vit_pkg::INDEX_WIDTH-1:0] index_value,
  input wire logic                           index_updated
);

  logic                           seen_out;
  logic [vit_pkg::INDEX_WIDTH-1:0] last_index;
  logic                           out_take;

  assign out_take = pop && !empty;

  // track the last delivered index
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_out <= 1'b0;
    end else if (out_take) begin
      seen_out <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      last_index <= index_value;
    end
  end

  // no result waits right after reset
  `VIT_ASSERT_SAME(a_empty_after_reset, clk, rst, $past(rst), empty, "result present after reset")

  // a stalled result holds
  `VIT_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(index_value) && $stable(index_updated), "stalled result changed")

  // the first transaction after reset starts the index
  `VIT_ASSERT_SAME(a_first_is_start, clk, rst, out_take && !seen_out, !index_updated && (index_value == vit_pkg::INDEX_START), "first result is not the start index")

  // an unscaled transaction repeats the previous index
  `VIT_ASSERT_SAME(a_hold_keeps_index, clk, rst, out_take && seen_out && !index_updated, index_value == last_index, "unscaled result changed the index")

endmodule

bind volume_index_tracker vit_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .index_value  (index_value),
  .index_updated(index_updated)
);

`default_nettype wire
